>>> rtl/core/dspc_pkg.sv
// Shared types, codes and constants for the date string parse/check core.
// No dependencies; every other file of the core imports this package.
package dspc_pkg;

  localparam int unsigned AccW  = 14;
  localparam int unsigned YearW = 15;

  localparam logic [AccW-1:0] AccMax       = 14'd9999;
  localparam logic [AccW-1:0] MinYearRst   = 14'd1980;
  localparam logic [AccW-1:0] MaxYearRst   = 14'd2099;
  localparam logic [AccW-1:0] CenturyRst   = 14'd1900;
  localparam logic [AccW-1:0] TwoDigitYear = 14'd100;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChDash  = 8'h2D;
  localparam logic [7:0] ChSlash = 8'h2F;

  // Configuration register indexes.
  localparam logic [1:0] RegMinYear = 2'd0;
  localparam logic [1:0] RegMaxYear = 2'd1;
  localparam logic [1:0] RegCentury = 2'd2;

  typedef enum logic [1:0] {
    ST_VALID  = 2'd0,
    ST_FORMAT = 2'd1,
    ST_RANGE  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    SEP_NONE  = 2'd0,
    SEP_DASH  = 2'd1,
    SEP_SLASH = 2'd2
  } sep_kind_t;

  // One finished string, handed from the front end to the checker.
  typedef struct packed {
    logic            fmt_bad;
    logic [AccW-1:0] month;
    logic [AccW-1:0] day;
    logic [AccW-1:0] year;
  } rec_t;

  typedef struct packed {
    logic [AccW-1:0] min_year;
    logic [AccW-1:0] max_year;
    logic [AccW-1:0] century;
  } cfg_t;

  // Days in a month, months 1 to 12; any other code returns 31.
  function automatic logic [4:0] days_in_month(input logic [3:0] month, input logic leap);
    logic [4:0] d;
    unique case (month)
      4'd2:                      d = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
      default:                   d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

>>> rtl/core/dspc_front.sv
// Front end: takes one string byte per beat, tracks separators and
// accumulates month, day and year. Uses dspc_pkg.
module dspc_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic [7:0]    ch,
  input  logic          last,
  output logic          push,
  output dspc_pkg::rec_t push_rec
);
  import dspc_pkg::*;

  logic [1:0]      sep_count_r, sep_count_nxt;
  sep_kind_t       sep_kind_r, sep_kind_nxt;
  logic            fmt_bad_r, fmt_bad_nxt;
  logic            ended_r, ended_nxt;
  logic [AccW-1:0] month_r, month_nxt;
  logic [AccW-1:0] day_r, day_nxt;
  logic [AccW-1:0] year_r, year_nxt;
  logic [2:0]      has_digit_r, has_digit_nxt;

  logic            is_digit;
  sep_kind_t       kind;
  logic [AccW-1:0] cur_acc;
  logic [17:0]     scaled;
  logic [AccW-1:0] new_acc;

  assign is_digit = (ch >= ChZero) && (ch <= ChNine);
  assign kind = (ch == ChDash) ? SEP_DASH : (ch == ChSlash) ? SEP_SLASH : SEP_NONE;

  always_comb begin
    unique case (sep_count_r)
      2'd0:    cur_acc = month_r;
      2'd1:    cur_acc = day_r;
      default: cur_acc = year_r;
    endcase
  end

  // acc * 10 + digit as two shifted adds, then saturate.
  assign scaled  = {1'b0, cur_acc, 3'b000} + {3'b000, cur_acc, 1'b0}
                 + {14'd0, ch[3:0] - ChZero[3:0]};
  assign new_acc = (scaled > {4'd0, AccMax}) ? AccMax : scaled[AccW-1:0];

  always_comb begin
    sep_count_nxt = sep_count_r;
    sep_kind_nxt  = sep_kind_r;
    fmt_bad_nxt   = fmt_bad_r;
    ended_nxt     = ended_r;
    month_nxt     = month_r;
    day_nxt       = day_r;
    year_nxt      = year_r;
    has_digit_nxt = has_digit_r;
    if (accept && !ended_r && !fmt_bad_r) begin
      if (ch == ChNul) begin
        ended_nxt = 1'b1;
      end else if (is_digit) begin
        unique case (sep_count_r)
          2'd0: begin
            month_nxt        = new_acc;
            has_digit_nxt[0] = 1'b1;
          end
          2'd1: begin
            day_nxt          = new_acc;
            has_digit_nxt[1] = 1'b1;
          end
          default: begin
            year_nxt         = new_acc;
            has_digit_nxt[2] = 1'b1;
          end
        endcase
      end else if (kind == SEP_NONE || (sep_kind_r != SEP_NONE && sep_kind_r != kind)
                   || sep_count_r >= 2'd2) begin
        fmt_bad_nxt = 1'b1;
        if (kind != SEP_NONE && sep_count_r != 2'd3) begin
          sep_count_nxt = sep_count_r + 2'd1;
        end
      end else begin
        sep_kind_nxt  = kind;
        sep_count_nxt = sep_count_r + 2'd1;
      end
    end
  end

  assign push             = accept && last;
  assign push_rec.fmt_bad = fmt_bad_nxt || (sep_count_nxt != 2'd2) || (has_digit_nxt != 3'b111);
  assign push_rec.month   = month_nxt;
  assign push_rec.day     = day_nxt;
  assign push_rec.year    = year_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || push) begin
      sep_count_r <= 2'd0;
      sep_kind_r  <= SEP_NONE;
      fmt_bad_r   <= 1'b0;
      ended_r     <= 1'b0;
      month_r     <= '0;
      day_r       <= '0;
      year_r      <= '0;
      has_digit_r <= 3'b000;
    end else begin
      sep_count_r <= sep_count_nxt;
      sep_kind_r  <= sep_kind_nxt;
      fmt_bad_r   <= fmt_bad_nxt;
      ended_r     <= ended_nxt;
      month_r     <= month_nxt;
      day_r       <= day_nxt;
      year_r      <= year_nxt;
      has_digit_r <= has_digit_nxt;
    end
  end

  // A third separator can only be counted as part of a format error.
  a_third_sep_is_bad: assert property (@(posedge clk) disable iff (!rst_n)
    (sep_count_r == 2'd3) |-> fmt_bad_r)
    else $error("third separator without format error");

endmodule

>>> rtl/core/dspc_queue.sv
// Short queue of finished string records between front end and checker.
// Uses dspc_pkg for the record type. DEPTH must be 2 or more.
module dspc_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dspc_pkg::rec_t push_rec,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output dspc_pkg::rec_t head_rec
);
  import dspc_pkg::*;

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  rec_t            mem_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;

  assign full      = (count_r == CntFull);
  assign not_empty = (count_r != '0);
  assign head_rec  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrLast) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrLast) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CntW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("pop from an empty queue");

endmodule

>>> rtl/core/dspc_back.sv
// Back end: checks one finished record against the year window and the
// days-per-month table, and holds the result beat. Uses dspc_pkg.
module dspc_back (
  input  logic            clk,
  input  logic            rst_n,
  input  dspc_pkg::cfg_t  cfg,
  input  logic            rec_valid,
  input  dspc_pkg::rec_t  rec,
  output logic            pop,
  output logic            res_valid,
  input  logic            res_ready,
  output dspc_pkg::status_t res_status,
  output logic [dspc_pkg::AccW-1:0]  res_month,
  output logic [dspc_pkg::AccW-1:0]  res_day,
  output logic [dspc_pkg::YearW-1:0] res_year
);
  import dspc_pkg::*;

  logic             valid_r;
  status_t          status_r, status_nxt;
  logic [AccW-1:0]  month_r;
  logic [AccW-1:0]  day_r;
  logic [YearW-1:0] year_r, year_nxt;
  logic             year_ok;
  logic             month_ok;
  logic [4:0]       max_day;

  assign year_nxt = (rec.year < TwoDigitYear)
                  ? ({1'b0, rec.year} + {1'b0, cfg.century})
                  : {1'b0, rec.year};
  assign year_ok  = (year_nxt >= {1'b0, cfg.min_year}) && (year_nxt <= {1'b0, cfg.max_year});
  assign month_ok = (rec.month >= 14'd1) && (rec.month <= 14'd12);
  assign max_day  = days_in_month(rec.month[3:0], year_nxt[1:0] == 2'b00);

  always_comb begin
    if (rec.fmt_bad) begin
      status_nxt = ST_FORMAT;
    end else if (!year_ok || !month_ok) begin
      status_nxt = ST_RANGE;
    end else if (rec.day < 14'd1 || rec.day > {9'd0, max_day}) begin
      status_nxt = ST_RANGE;
    end else begin
      status_nxt = ST_VALID;
    end
  end

  assign pop = rec_valid && (!valid_r || res_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (res_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      status_r <= status_nxt;
      month_r  <= rec.month;
      day_r    <= rec.day;
      year_r   <= year_nxt;
    end
  end

  assign res_valid  = valid_r;
  assign res_status = status_r;
  assign res_month  = month_r;
  assign res_day    = day_r;
  assign res_year   = year_r;

  a_valid_date_sane: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && status_r == ST_VALID) |->
      (month_r >= 14'd1 && month_r <= 14'd12 && day_r >= 14'd1 && day_r <= 14'd31))
    else $error("valid status on an impossible date");

endmodule

>>> rtl/core/date_string_parse_check_core.sv
// Top level of the date string parse/check core: configuration registers,
// front end, record queue and checker. Uses dspc_pkg and the dspc_* modules.
//
// Usage: a month-day-year date string (for example "12/31/1999") streams in
// on the in_ channel, one ASCII byte per beat, with in_tlast on its final
// byte. Bytes must be digits or one kind of separator ('-' or '/'), exactly
// two separators; a zero byte ends the string and later bytes are ignored.
// For each beat marked last the core emits one result beat on out_ carrying
// the status (valid, bad format, out of range) and the parsed fields.
// Years below 100 get the century_base register added before checking.
//
// Throughput is one byte per cycle while the queue is not full; the front end
// updates its accumulators for each accepted byte. A finished string moves
// through a queue of QUEUE_DEPTH records into the checker: after the last
// byte is accepted the record passes the queue memory and then the checker's
// output register. If the receiver stalls, results wait in the output
// register and the queue; bytes keep flowing until the queue is full.
// Reset (synchronous, active low) clears all parsing state and the queue,
// and loads min_year 1980, max_year 2099 and century_base 1900. The
// configuration registers are written through cfg_we/cfg_addr/cfg_wdata.
module date_string_parse_check_core #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic        in_tlast,   // last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [1:0] status, [15:2] month, [29:16] day,
                                  // [44:30] year, [47:45] zero
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [13:0] cfg_wdata
);
  import dspc_pkg::*;

  cfg_t    cfg_r;
  logic    accept;
  logic    push;
  rec_t    push_rec;
  logic    q_full;
  logic    q_valid;
  rec_t    q_rec;
  logic    pop;
  status_t res_status;
  logic [AccW-1:0]  res_month;
  logic [AccW-1:0]  res_day;
  logic [YearW-1:0] res_year;

  // Configuration writes; index 3 has no register and is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_year <= MinYearRst;
      cfg_r.max_year <= MaxYearRst;
      cfg_r.century  <= CenturyRst;
    end else if (cfg_we) begin
      case (cfg_addr)
        RegMinYear: cfg_r.min_year <= cfg_wdata;
        RegMaxYear: cfg_r.max_year <= cfg_wdata;
        RegCentury: cfg_r.century  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Bytes are taken whenever the queue can hold one more finished string.
  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  dspc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .ch       (in_tdata),
    .last     (in_tlast),
    .push     (push),
    .push_rec (push_rec)
  );

  dspc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_rec  (push_rec),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head_rec  (q_rec)
  );

  dspc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .rec_valid  (q_valid),
    .rec        (q_rec),
    .pop        (pop),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res_status (res_status),
    .res_month  (res_month),
    .res_day    (res_day),
    .res_year   (res_year)
  );

  assign out_tdata = {3'b000, res_year, res_day, res_month, res_status};

endmodule

>>> tb/date_result_checker.sv
// Scoreboard for the date string parse/check core: watches the byte, result and
// register ports, predicts each result beat and compares it field by field.
// Depends on dspc_pkg for widths, character codes, register indexes and status codes.
module date_result_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_tready,
  input  logic [7:0]         in_tdata,
  input  logic               in_tlast,
  input  logic               out_tvalid,
  input  logic               out_tready,
  input  logic [47:0]        out_tdata,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [13:0]        cfg_wdata,
  output int unsigned        failures,
  output int unsigned        outstanding
);
  import dspc_pkg::*;

  typedef struct packed {
    status_t          status;
    logic [AccW-1:0]  month;
    logic [AccW-1:0]  day;
    logic [YearW-1:0] year;
  } date_result_t;

  date_result_t expected_dates[$];

  logic [AccW-1:0] min_year, max_year, century;
  logic [1:0]      sep_seen;
  sep_kind_t       sep_style;
  logic            bad_format, terminated;
  logic [AccW-1:0] month_acc, day_acc, year_acc;
  logic [2:0]      digit_fields;

  function automatic void clear_date();
    sep_seen     = 2'd0;
    sep_style    = SEP_NONE;
    bad_format   = 1'b0;
    terminated   = 1'b0;
    month_acc    = '0;
    day_acc      = '0;
    year_acc     = '0;
    digit_fields = 3'b000;
  endfunction

  // Decimal accumulate, pinned at the saturation value.
  function automatic logic [AccW-1:0] push_digit(input logic [AccW-1:0] acc,
                                                 input logic [7:0] c);
    int unsigned v, d;
    v = 32'(acc);
    d = 32'(c) - 32'(ChZero);
    v = v * 10 + d;
    return (v > AccMax) ? AccMax : v[AccW-1:0];
  endfunction

  function automatic int unsigned month_length(input int unsigned m, input bit leap);
    case (m)
      2:           return leap ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  function automatic void take_char(input logic [7:0] c);
    sep_kind_t k;
    if (terminated || bad_format) return;
    if (c == ChNul) begin
      terminated = 1'b1;
      return;
    end
    if (c >= ChZero && c <= ChNine) begin
      case (sep_seen)
        2'd0: begin
          month_acc       = push_digit(month_acc, c);
          digit_fields[0] = 1'b1;
        end
        2'd1: begin
          day_acc         = push_digit(day_acc, c);
          digit_fields[1] = 1'b1;
        end
        default: begin
          year_acc        = push_digit(year_acc, c);
          digit_fields[2] = 1'b1;
        end
      endcase
      return;
    end
    if (c == ChDash) k = SEP_DASH;
    else if (c == ChSlash) k = SEP_SLASH;
    else k = SEP_NONE;
    if (k == SEP_NONE || (sep_style != SEP_NONE && sep_style != k) || sep_seen >= 2'd2) begin
      bad_format = 1'b1;
      if (k != SEP_NONE && sep_seen != 2'd3) sep_seen = sep_seen + 2'd1;
    end else begin
      sep_style = k;
      sep_seen  = sep_seen + 2'd1;
    end
  endfunction

  function automatic date_result_t close_date();
    date_result_t r;
    logic [YearW-1:0] yr;
    int unsigned mdays;
    yr = {1'b0, year_acc};
    if (year_acc < TwoDigitYear) yr = yr + {1'b0, century};
    if (bad_format || sep_seen != 2'd2 || digit_fields != 3'b111) begin
      r.status = ST_FORMAT;
    end else if (yr < min_year || yr > max_year) begin
      r.status = ST_RANGE;
    end else if (month_acc < 1 || month_acc > 12) begin
      r.status = ST_RANGE;
    end else begin
      mdays = month_length(32'(month_acc), yr[1:0] == 2'b00);
      r.status = (day_acc < 1 || day_acc > mdays) ? ST_RANGE : ST_VALID;
    end
    r.month = month_acc;
    r.day   = day_acc;
    r.year  = yr;
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk) begin : watch
    date_result_t want;
    if (!rst_n) begin
      min_year = MinYearRst;
      max_year = MaxYearRst;
      century  = CenturyRst;
      clear_date();
      expected_dates.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          RegMinYear: min_year = cfg_wdata;
          RegMaxYear: max_year = cfg_wdata;
          RegCentury: century  = cfg_wdata;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (expected_dates.size() == 0) begin
          $error("result beat with no date pending: tdata %h", out_tdata);
          failures++;
        end else begin
          want = expected_dates.pop_front();
          check_field("status", 32'(want.status), 32'(out_tdata[1:0]));
          check_field("month", 32'(want.month), 32'(out_tdata[15:2]));
          check_field("day", 32'(want.day), 32'(out_tdata[29:16]));
          check_field("year", 32'(want.year), 32'(out_tdata[44:30]));
          check_field("pad", 0, 32'(out_tdata[47:45]));
        end
      end
      if (in_tvalid && in_tready) begin
        take_char(in_tdata);
        if (in_tlast) begin
          expected_dates.push_back(close_date());
          clear_date();
        end
      end
    end
    outstanding = expected_dates.size();
  end

endmodule

>>> tb/tb_top.sv
// Top of the date string parse/check regression: clock, reset, byte stimulus,
// register writes and verdict. Instantiates date_string_parse_check_core and
// date_result_checker; uses dspc_pkg for character codes and register indexes.
module tb_top;
  import dspc_pkg::*;

  // Index just past the register list; the core must ignore writes to it.
  localparam logic [1:0]  RegUnused    = 2'd3;
  localparam int unsigned PhaseBytes   = 160;
  localparam int unsigned NumPhases    = 8;
  // Idle cycles that each drain adds after the last predicted result beat.
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned MaxGap       = 40;

  // Ways a random date string is damaged on purpose.
  typedef enum int unsigned {
    BREAK_NONE,
    BREAK_MIX,
    BREAK_THIRD,
    BREAK_EMPTY,
    BREAK_STRAY,
    BREAK_ONE_SEP,
    BREAK_NOISE
  } break_kind_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] ch
  logic        in_tlast;   // last
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // [1:0] status, [15:2] month, [29:16] day, [44:30] year
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [13:0] cfg_wdata;

  int unsigned failures;
  int unsigned outstanding;

  // Idle and stall odds, in percent per cycle, set by each phase.
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned bytes_sent;

  // Our copy of the year registers, used only to aim random years near the window.
  logic [13:0] cur_min, cur_max, cur_century;

  // The string being assembled for the next run of byte beats.
  logic [7:0] date_text[$];

  always #5 clk = ~clk;

  date_string_parse_check_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  date_result_checker date_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .failures    (failures),
    .outstanding (outstanding)
  );

  // The receiver stalls at random; a new decision is made every falling edge.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Drive one byte beat and hold it until the core takes it. The idle gap in
  // front of the beat is geometric, so the long-run idle share matches the odds.
  task automatic send_byte(input logic [7:0] c, input logic l);
    int unsigned gap;
    gap = 0;
    while (gap < MaxGap && $urandom_range(99) < send_idle_pct) gap++;
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= l;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_text();
    foreach (date_text[i]) send_byte(date_text[i], i == date_text.size() - 1);
    bytes_sent += date_text.size();
  endtask

  // Stop sending and wait until every predicted result beat has come out.
  // The extra cycles cover bytes without a result that may still be in flight.
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [13:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_years(input logic [13:0] lo, input logic [13:0] hi,
                           input logic [13:0] base);
    write_reg(RegMinYear, lo);
    write_reg(RegMaxYear, hi);
    write_reg(RegCentury, base);
    cur_min     = lo;
    cur_max     = hi;
    cur_century = base;
  endtask

  function automatic void load_text(input string s);
    date_text.delete();
    for (int i = 0; i < s.len(); i++) date_text.push_back(s[i]);
  endfunction

  // Append a decimal number, padded with leading zeros to min_digits.
  function automatic void add_number(input int unsigned value, input int unsigned min_digits);
    logic [7:0] digits[$];
    logic [7:0] d;
    int unsigned v;
    v = value;
    do begin
      d = ChZero + 8'(v % 10);
      digits.push_front(d);
      v = v / 10;
    end while (v != 0);
    while (digits.size() < min_digits) digits.push_front(ChZero);
    foreach (digits[i]) date_text.push_back(digits[i]);
  endfunction

  // A field is usually the given number; now and then a long run of digits
  // that can drive the accumulator into saturation.
  function automatic void add_field(input int unsigned value);
    logic [7:0] d;
    if ($urandom_range(19) == 0) begin
      repeat ($urandom_range(7, 5)) begin
        d = ChZero + 8'($urandom_range(9));
        date_text.push_back(d);
      end
    end else begin
      add_number(value, $urandom_range(2, 1));
    end
  endfunction

  // Build one random date string. Most are well formed with random content,
  // so that the range and calendar checks get exercised; the rest are broken
  // in one specific way or are plain byte noise.
  function automatic void build_date();
    break_kind_t brk;
    logic [7:0]  sep, other, b;
    int unsigned skip, lo, hi, year_val, tail;
    date_text.delete();
    if ($urandom_range(99) < 65) begin
      brk = BREAK_NONE;
    end else begin
      case ($urandom_range(5))
        0:       brk = BREAK_MIX;
        1:       brk = BREAK_THIRD;
        2:       brk = BREAK_EMPTY;
        3:       brk = BREAK_STRAY;
        4:       brk = BREAK_ONE_SEP;
        default: brk = BREAK_NOISE;
      endcase
    end

    if (brk == BREAK_NOISE) begin
      repeat ($urandom_range(8, 1)) begin
        b = 8'($urandom_range(255));
        date_text.push_back(b);
      end
      return;
    end

    sep   = $urandom_range(1) ? ChDash : ChSlash;
    other = (sep == ChDash) ? ChSlash : ChDash;
    skip  = (brk == BREAK_EMPTY) ? $urandom_range(2) : 3;

    if (skip != 0) add_field(($urandom_range(9) < 8) ? $urandom_range(12, 1) : $urandom_range(99));
    date_text.push_back(sep);
    if (skip != 1) add_field(($urandom_range(9) < 8) ? $urandom_range(31, 1) : $urandom_range(99));
    if (brk != BREAK_ONE_SEP) date_text.push_back((brk == BREAK_MIX) ? other : sep);
    if (skip != 2) begin
      if ($urandom_range(1)) begin
        year_val = $urandom_range(99);
      end else begin
        // Aim at the year window, a little past each edge.
        lo = (cur_min < cur_max) ? 32'(cur_min) : 32'(cur_max);
        hi = (cur_min < cur_max) ? 32'(cur_max) : 32'(cur_min);
        lo = (lo > 3) ? lo - 3 : 0;
        hi = hi + 3;
        year_val = $urandom_range(hi, lo);
      end
      add_field(year_val);
    end
    if (brk == BREAK_THIRD) begin
      date_text.push_back(sep);
      if ($urandom_range(1)) add_number($urandom_range(99), 1);
    end
    if (brk == BREAK_STRAY) begin
      b = 8'($urandom_range(255));
      date_text.insert($urandom_range(date_text.size()), b);
    end

    // Sometimes a terminator, and sometimes junk after it that must be ignored.
    tail = $urandom_range(9);
    if (tail < 2) date_text.push_back(ChNul);
    if (tail == 1) begin
      repeat ($urandom_range(4, 1)) begin
        b = 8'($urandom_range(255));
        date_text.push_back(b);
      end
    end
  endfunction

  initial begin : stimulus
    int unsigned phase_start, strings;
    logic [13:0] lo_year;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tlast    <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_addr    <= RegMinYear;
    cfg_wdata   <= '0;
    rst_n       <= 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    bytes_sent    = 0;
    strings       = 0;
    cur_min       = MinYearRst;
    cur_max       = MaxYearRst;
    cur_century   = CenturyRst;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Directed strings with the reset year window and no idling.
    // A leap day with a two-digit year that gets the century added.
    load_text("2/29/96");
    send_text();
    // The day field is empty.
    load_text("1--5");
    send_text();
    // Separators only, the third one among them.
    load_text("---");
    send_text();
    // Terminator, then a byte that must be ignored; the year field stays empty.
    load_text("1/2");
    date_text.push_back(ChNul);
    date_text.push_back(8'hFF);
    send_text();
    // A lone zero byte that is also the last byte.
    date_text.delete();
    date_text.push_back(ChNul);
    send_text();
    // Mixed separators; the digit after the error must not count.
    load_text("1-2/3");
    send_text();
    drain();

    for (int p = 0; p < NumPhases; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 83; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 83; end
        default: begin send_idle_pct = 38; stall_pct = 38; end
      endcase

      // The core is idle here: the previous phase ended with a drain.
      case (p)
        1: set_years(14'd0, 14'h3FFF, 14'd0);
        2: set_years(14'd2000, 14'd1990, 14'd9900);   // empty window
        3: begin
          set_years(14'd1900, 14'd2100, 14'd2000);
          write_reg(RegUnused, 14'($urandom_range(16383)));
        end
        4, 6: begin
          lo_year = 14'($urandom_range(9999));
          set_years(lo_year, 14'(lo_year + $urandom_range(300)),
                    14'($urandom_range(99) * 100));
        end
        5: set_years(14'($urandom_range(9999)), 14'h3FFF, 14'h3FFF);
        7: set_years(MinYearRst, MaxYearRst, CenturyRst);
        default: ;
      endcase

      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PhaseBytes) begin
        build_date();
        send_text();
        strings++;
        // Let the result path run dry every so often.
        if (strings % 12 == 11) drain();
      end
      drain();
    end

    if (failures == 0) begin
      $display("date_string_parse_check_core regression: pass");
    end else begin
      $display("date_string_parse_check_core regression: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, even with every gap at its cap.
  initial begin
    #3000000;
    $display("date_string_parse_check_core regression: fail");
    $finish;
  end

endmodule

>>> date_string_parse_check_core.f
rtl/core/dspc_pkg.sv
rtl/core/dspc_front.sv
rtl/core/dspc_queue.sv
rtl/core/dspc_back.sv
rtl/core/date_string_parse_check_core.sv
tb/date_result_checker.sv
tb/tb_top.sv
